@@ design/rpcg_pkg.sv @@
package rpcg_pkg;

  // Generator arithmetic
  localparam int unsigned StateW = 31;
  localparam logic [StateW-1:0] PmMod = 31'h7FFF_FFFF;
  localparam logic [14:0] PmMul = 15'd16807;
  localparam int unsigned ProdW = StateW + 15;

  // Gap interval [1,2]: reject only the top state, split at the bucket size
  localparam logic [StateW-1:0] GapLimit = 31'd2147483646;
  localparam logic [StateW-1:0] GapBucket = 31'd1073741823;

  // Character interval [33,126]: 94 buckets of 22845570 states.
  // x / 22845570 equals 94x / CharLimit, and CharLimit is 2^31 - 68, so the
  // top bits of 94x give the quotient up to one correction step.
  localparam int unsigned CharW = 7;
  localparam logic [CharW-1:0] CharLo = 7'd33;
  localparam logic [StateW-1:0] CharLimit = 31'd2147483580;
  localparam logic [CharW-1:0] CharSpan = 7'd94;
  localparam logic [CharW-1:0] CharFold = 7'd68;
  localparam int unsigned ScaledW = StateW + CharW;

  // Input action codes
  localparam logic ActReseed = 1'b0;
  localparam logic ActGenerate = 1'b1;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgAllowSymbols = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgAllowDigits = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgAllowUpper = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgAllowLookalikes = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgVowelPattern = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic load_seed;
    logic load_count;
    logic mul;
    logic reduce;
    logic gap_load;
    logic div_init;
    logic div_step;
    logic gap_dec;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic gap_reject;
    logic char_reject;
    logic filter_reject;
    logic vowel;
    logic vowel_mode;
    logic gap_zero;
    logic count_zero;
    logic last;
    logic out_free;
  } dp_sts_t;

  function automatic logic is_digit(input logic [CharW-1:0] c);
    return (c >= 7'd48) && (c <= 7'd57);
  endfunction

  function automatic logic is_upper(input logic [CharW-1:0] c);
    return (c >= 7'd65) && (c <= 7'd90);
  endfunction

  function automatic logic is_lower(input logic [CharW-1:0] c);
    return (c >= 7'd97) && (c <= 7'd122);
  endfunction

  // 0 O o I l 1 ( ) [ ] { } ; : | - _ B 8
  function automatic logic is_lookalike(input logic [CharW-1:0] c);
    logic hit;
    hit = 1'b0;
    case (c)
      7'd48, 7'd79, 7'd111, 7'd73, 7'd108, 7'd49, 7'd40, 7'd41, 7'd91, 7'd93,
      7'd123, 7'd125, 7'd59, 7'd58, 7'd124, 7'd45, 7'd95, 7'd66, 7'd56: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // a e i o u y A E I O U Y
  function automatic logic is_vowel(input logic [CharW-1:0] c);
    logic hit;
    hit = 1'b0;
    case (c)
      7'd97, 7'd101, 7'd105, 7'd111, 7'd117, 7'd121,
      7'd65, 7'd69, 7'd73, 7'd79, 7'd85, 7'd89: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

@@ design/random_password_char_generator.sv @@
// Channel   Handshake                Payload
// in        in_valid_i / in_ready_o  action_i, seed_value_i, char_count_i
// out       out_valid_o/out_ready_i  character_o, last_char_o
// cfg       cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// A reseed completes in the idle state. A generator step passes the
// multiply, fold and range-check states; a character candidate adds
// the bucket-division and filtering states, and each emit its own state.
// Rejected candidates repeat the whole step, so the time a string takes
// is data dependent. Reset loads state 1 and the register defaults. A
// stalled output holds the controller in its emit state.
module random_password_char_generator import rpcg_pkg::*; #(
  parameter int unsigned MAX_CHARS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic [StateW-1:0]  seed_value_i,
  input  logic [6:0]         char_count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CharW-1:0]   character_o,
  output logic               last_char_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic               cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  rpcg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rpcg_dp #(
    .MAX_CHARS (MAX_CHARS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .seed_value_i (seed_value_i),
    .char_count_i (char_count_i),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .character_o  (character_o),
    .last_char_o  (last_char_o)
  );

endmodule

@@ design/rpcg_dp.sv @@
module rpcg_dp import rpcg_pkg::*; #(
  parameter int unsigned MAX_CHARS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  input  logic [StateW-1:0] seed_value_i,
  input  logic [6:0]        char_count_i,
  input  logic              cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic              cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CharW-1:0]  character_o,
  output logic              last_char_o
);

  localparam int unsigned CntW = $clog2(MAX_CHARS + 1);
  localparam logic [6:0] MaxCount = 7'(MAX_CHARS);

  logic [StateW-1:0] gen_q, gen_d;
  logic [ProdW-1:0]  prod_q;
  logic [ScaledW-1:0] scaled_q;
  logic [CharW-1:0]  quo_q;
  logic [1:0]        gap_q;
  logic [CntW-1:0]   cnt_q;
  logic              out_valid_q;
  logic [CharW-1:0]  char_q;
  logic              last_q;
  logic              sym_q, dig_q, up_q, look_q, vow_q;

  logic [StateW:0]   fold;
  logic [StateW-1:0] reduced;
  logic [CharW-1:0]  bkt_hi;
  logic [2*CharW-1:0] bkt_add;
  logic [StateW:0]   bkt_rem;
  logic [CharW-1:0]  cand;
  logic [6:0]        count_sat;

  // Fold the product modulo 2^31-1; the result is never zero for a nonzero state
  assign fold = {1'b0, prod_q[StateW-1:0]} + {{(2*StateW+1-ProdW){1'b0}}, prod_q[ProdW-1:StateW]};
  assign reduced = fold[StateW-1:0] + {{(StateW-1){1'b0}}, fold[StateW]};

  // Quotient estimate from the top bits of 94x, remainder folded back by 68 per unit
  assign bkt_hi  = scaled_q[ScaledW-1:StateW];
  assign bkt_add = bkt_hi * CharFold;
  assign bkt_rem = {1'b0, scaled_q[StateW-1:0]} + {{(StateW+1-2*CharW){1'b0}}, bkt_add};

  assign cand = CharLo + quo_q;
  assign count_sat = (char_count_i > MaxCount) ? MaxCount : char_count_i;

  // Generator state: seed load or new draw
  always_comb begin
    gen_d = gen_q;
    if (cmd_i.load_seed) begin
      gen_d = ((seed_value_i == '0) || (seed_value_i == PmMod)) ? StateW'(1) : seed_value_i;
    end else if (cmd_i.reduce) begin
      gen_d = reduced;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= StateW'(1);
    end else begin
      gen_q <= gen_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q  <= 1'b1;
      dig_q  <= 1'b1;
      up_q   <= 1'b1;
      look_q <= 1'b1;
      vow_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgAllowSymbols:    sym_q  <= cfg_data_i;
        CfgAllowDigits:     dig_q  <= cfg_data_i;
        CfgAllowUpper:      up_q   <= cfg_data_i;
        CfgAllowLookalikes: look_q <= cfg_data_i;
        CfgVowelPattern:    vow_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Multiply, bucket scaling and quotient, gap and count
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= gen_q * PmMul;
    end
    if (cmd_i.div_init) begin
      scaled_q <= gen_q * CharSpan;
    end
    if (cmd_i.div_step) begin
      quo_q <= bkt_hi + CharW'(bkt_rem >= {1'b0, CharLimit});
    end
    if (cmd_i.gap_load) begin
      gap_q <= (gen_q >= GapBucket) ? 2'd2 : 2'd1;
    end else if (cmd_i.gap_dec) begin
      gap_q <= gap_q - 2'd1;
    end
    if (cmd_i.load_count) begin
      cnt_q <= CntW'(count_sat);
    end else if (cmd_i.emit) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      char_q <= cand;
      last_q <= (cnt_q == CntW'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_char_o = last_q;

  // Status toward the controller
  always_comb begin
    sts_o.gap_reject    = (gen_q >= GapLimit);
    sts_o.char_reject   = (gen_q >= CharLimit);
    sts_o.filter_reject = (!sym_q && !(is_digit(cand) || is_upper(cand) || is_lower(cand))) ||
                          (!dig_q && is_digit(cand)) ||
                          (!up_q && is_upper(cand)) ||
                          (!look_q && is_lookalike(cand));
    sts_o.vowel         = is_vowel(cand);
    sts_o.vowel_mode    = vow_q;
    sts_o.gap_zero      = (gap_q == 2'd0);
    sts_o.count_zero    = (cnt_q == '0);
    sts_o.last          = (cnt_q == CntW'(1));
    sts_o.out_free      = !out_valid_q || out_ready_i;
  end

  a_state_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gen_q != '0) && (gen_q != PmMod))
    else $error("generator state locked");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("emit over an untaken result");

  a_gap_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.gap_dec |-> (gap_q != 2'd0))
    else $error("gap decrement below zero");

  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (cnt_q != '0))
    else $error("emit with no characters left");

endmodule

@@ design/rpcg_ctrl.sv @@
module rpcg_ctrl import rpcg_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    action_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RED,
    ST_CHK,
    ST_DIV,
    ST_EVAL,
    ST_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic             kind_gap_q, kind_gap_d;
  logic             regap_q, regap_d;

  always_comb begin
    state_d    = state_q;
    kind_gap_d = kind_gap_q;
    regap_d    = regap_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (action_i == ActGenerate) begin
            cmd_o.load_count = 1'b1;
            kind_gap_d = 1'b1;
            state_d = ST_MUL;
          end else begin
            cmd_o.load_seed = 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = ST_RED;
      end
      ST_RED: begin
        cmd_o.reduce = 1'b1;
        state_d = ST_CHK;
      end
      // Reject out-of-range draws, else finish the gap or start the divide
      ST_CHK: begin
        if (kind_gap_q) begin
          if (sts_i.gap_reject) begin
            state_d = ST_MUL;
          end else begin
            cmd_o.gap_load = 1'b1;
            kind_gap_d = 1'b0;
            state_d = sts_i.count_zero ? ST_IDLE : ST_MUL;
          end
        end else if (sts_i.char_reject) begin
          state_d = ST_MUL;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d = ST_EVAL;
      end
      // Apply class filters and vowel spacing
      ST_EVAL: begin
        regap_d = 1'b0;
        if (sts_i.filter_reject) begin
          state_d = ST_MUL;
        end else if (sts_i.vowel_mode) begin
          if (sts_i.gap_zero) begin
            if (sts_i.vowel) begin
              regap_d = 1'b1;
              state_d = ST_EMIT;
            end else begin
              state_d = ST_MUL;
            end
          end else if (sts_i.vowel) begin
            state_d = ST_MUL;
          end else begin
            cmd_o.gap_dec = 1'b1;
            state_d = ST_EMIT;
          end
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (regap_q) begin
            kind_gap_d = 1'b1;
            state_d = ST_MUL;
          end else begin
            state_d = sts_i.last ? ST_IDLE : ST_MUL;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      kind_gap_q <= 1'b0;
      regap_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      kind_gap_q <= kind_gap_d;
      regap_q    <= regap_d;
    end
  end

endmodule
